FILE: rtl/core/bedc_pkg.sv
package bedc_pkg;

    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned DELTA_W  = 17;
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned EV_FIELDS = 3;
    localparam int unsigned IN_W     = 72;
    localparam int unsigned OUT_W    = 48;
    localparam logic [TICK_W-1:0] WINDOW_RESET = 32'd500;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_HELD   = 3'd3,
        EV_DOUBLE = 3'd4
    } t_event;

    typedef logic [1:0] t_count;

endpackage

FILE: rtl/core/button_edge_double_click_detector_core.sv
// Mouse button edge and double-click detector. Each input word carries the
// three button levels, a wrapping 32-bit tick time and the signed cursor
// position; each output word carries one event code per button (none, down,
// up, held, double click) and the 17-bit cursor delta from the previous word.
// A double click is reported on the second release when it comes no more than
// r_window ticks after the first press. The block takes one word per cycle:
// an input register feeds a single pass of per-button compare and subtract
// logic into an output register, so one word is accepted each cycle that the
// output side keeps up, and a word is held on each side while the output
// stalls. A taken word is held in the input register and moves on to the
// output register when the output register is empty or being read.
// The window register is written through i_cfg_wr_en and i_cfg_wr_data and
// resets to 500; write it only while no word is in flight.
module button_edge_double_click_detector_core
    import bedc_pkg::*;
#(
    parameter int unsigned BUTTON_COUNT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TICK_W-1:0] i_cfg_wr_data,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // button_levels[2:0], tick_time[34:3], cursor_x[50:35], cursor_y[66:51]
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // left_event[2:0], right_event[5:3], middle_event[8:6],
    // delta_x[25:9], delta_y[42:26]
    output logic [OUT_W-1:0]  o_m_axis_tdata
);

    logic                    r_in_valid;
    logic [LEVEL_W-1:0]      r_levels;
    logic [TICK_W-1:0]       r_now;
    logic signed [POS_W-1:0] r_cx;
    logic signed [POS_W-1:0] r_cy;

    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    logic [TICK_W-1:0]       r_window;
    logic                    r_prev     [BUTTON_COUNT];
    t_count                  r_count    [BUTTON_COUNT];
    logic [TICK_W-1:0]       r_start    [BUTTON_COUNT];
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;

    logic                    n_prev     [BUTTON_COUNT];
    t_count                  n_count    [BUTTON_COUNT];
    logic [TICK_W-1:0]       n_start    [BUTTON_COUNT];
    t_event                  n_ev       [BUTTON_COUNT];
    t_event                  w_field    [EV_FIELDS];

    logic                    w_move;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic [OUT_W-1:0]        n_out_data;

    assign w_move          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_move;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // per-button edge classification and click tracking
    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_btn
        logic              w_cur;
        logic [TICK_W-1:0] w_elapsed;
        logic              w_late;
        t_count            w_c1;

        if (g < LEVEL_W) begin : g_lvl
            assign w_cur = r_levels[g];
        end else begin : g_nolvl
            assign w_cur = 1'b0;
        end

        assign w_elapsed = r_now - r_start[g];
        assign w_late    = w_elapsed >= r_window;

        always_comb begin
            n_prev[g]  = w_cur;
            n_count[g] = r_count[g];
            n_start[g] = r_start[g];
            w_c1       = r_count[g];
            unique case ({r_prev[g], w_cur})
                2'b01: begin
                    n_ev[g] = EV_DOWN;
                    if (r_count[g] == 2'd1 && w_late) begin
                        w_c1 = 2'd0;
                    end
                    n_count[g] = (w_c1 < 2'd2) ? w_c1 + 2'd1 : w_c1;
                    if (n_count[g] == 2'd1) begin
                        n_start[g] = r_now;
                    end
                end
                2'b10: begin
                    n_ev[g] = EV_UP;
                    if (r_count[g] == 2'd1) begin
                        if (w_late) begin
                            n_count[g] = 2'd0;
                        end
                    end else if (r_count[g] == 2'd2) begin
                        if (w_elapsed <= r_window) begin
                            n_ev[g] = EV_DOUBLE;
                        end
                        n_count[g] = 2'd0;
                    end
                end
                2'b11: n_ev[g] = EV_HELD;
                default: n_ev[g] = EV_NONE;
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_prev[g]  <= 1'b0;
                r_count[g] <= 2'd0;
                r_start[g] <= '0;
            end else if (w_move) begin
                r_prev[g]  <= n_prev[g];
                r_count[g] <= n_count[g];
                r_start[g] <= n_start[g];
            end
        end
    end

    for (genvar f = 0; f < EV_FIELDS; f++) begin : g_field
        if (f < BUTTON_COUNT) begin : g_have
            assign w_field[f] = n_ev[f];
        end else begin : g_absent
            assign w_field[f] = EV_NONE;
        end
    end

    assign w_dx = DELTA_W'(r_cx) - DELTA_W'(r_px);
    assign w_dy = DELTA_W'(r_cy) - DELTA_W'(r_py);

    assign n_out_data = {5'd0, w_dy, w_dx, w_field[2], w_field[1], w_field[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_px        <= r_cx;
                r_py        <= r_cy;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_levels <= i_s_axis_tdata[LEVEL_W-1:0];
            r_now    <= i_s_axis_tdata[LEVEL_W +: TICK_W];
            r_cx     <= i_s_axis_tdata[LEVEL_W+TICK_W +: POS_W];
            r_cy     <= i_s_axis_tdata[LEVEL_W+TICK_W+POS_W +: POS_W];
        end
        if (w_move) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: rtl/core/bedc_checker.sv
module bedc_checker
    import bedc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // event codes stay in range
    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:0] <= 3'd4) && (o_m_axis_tdata[5:3] <= 3'd4)
            && (o_m_axis_tdata[8:6] <= 3'd4))
        else $error("event code out of range");

    // both stages full after accepting into a stalled output
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready && i_s_axis_tvalid && o_s_axis_tready
            |=> o_m_axis_tvalid && (!o_s_axis_tready || i_m_axis_tready))
        else $error("word accepted without room");

    // no output word right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind button_edge_double_click_detector_core bedc_checker u_bedc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: bench/tb_top.sv
module tb_top;
    import bedc_pkg::*;

    // packed from the top down, so levels lands in the lowest bits
    typedef struct packed {
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
        logic [TICK_W-1:0]       tick;
        logic [LEVEL_W-1:0]      levels;
    } t_frame;

    typedef struct packed {
        t_event                    left;
        t_event                    right;
        t_event                    middle;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } t_click_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [TICK_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic [IN_W-1:0]   s_data = '0;
    logic              m_ready = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [OUT_W-1:0]  m_data;

    button_edge_double_click_detector_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // frames waiting to be offered, and reports waiting to come out
    t_frame        pending_frames[$];
    t_click_report expected_reports[$];
    int            fails = 0;
    logic          word_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;

    // shadow state of the detector
    logic [TICK_W-1:0]  window_cfg = WINDOW_RESET;
    logic [LEVEL_W-1:0] prev_level = '0;
    t_count             click_cnt[EV_FIELDS] = '{default: '0};
    logic [TICK_W-1:0]  win_start[EV_FIELDS] = '{default: '0};
    logic [POS_W-1:0]   prev_x = '0;
    logic [POS_W-1:0]   prev_y = '0;

    // frame generator state
    logic [LEVEL_W-1:0] gen_levels = '0;
    logic [TICK_W-1:0]  gen_tick = '0;
    logic [POS_W-1:0]   gen_x = '0;
    logic [POS_W-1:0]   gen_y = '0;
    int unsigned        gen_span = 300;

    function automatic t_click_report predict_report(t_frame f);
        t_click_report r;
        t_event ev;
        t_event evs[EV_FIELDS];
        logic cur;
        logic [TICK_W-1:0] elapsed;
        for (int b = 0; b < EV_FIELDS; b++) begin
            cur = f.levels[b];
            if (!prev_level[b] && cur) ev = EV_DOWN;
            else if (prev_level[b] && !cur) ev = EV_UP;
            else if (cur) ev = EV_HELD;
            else ev = EV_NONE;
            elapsed = f.tick - win_start[b];
            prev_level[b] = cur;
            case (ev)
                EV_DOWN: begin
                    if (click_cnt[b] == 2'd1 && elapsed >= window_cfg) click_cnt[b] = 2'd0;
                    if (click_cnt[b] < 2'd2) click_cnt[b] = click_cnt[b] + 2'd1;
                    if (click_cnt[b] == 2'd1) win_start[b] = f.tick;
                end
                EV_UP: begin
                    if (click_cnt[b] == 2'd1) begin
                        if (elapsed >= window_cfg) click_cnt[b] = 2'd0;
                    end else if (click_cnt[b] == 2'd2) begin
                        if (elapsed <= window_cfg) ev = EV_DOUBLE;
                        click_cnt[b] = 2'd0;
                    end
                end
                default: ;
            endcase
            evs[b] = ev;
        end
        r.left   = evs[0];
        r.right  = evs[1];
        r.middle = evs[2];
        r.dx = {f.x[POS_W-1], f.x} - {prev_x[POS_W-1], prev_x};
        r.dy = {f.y[POS_W-1], f.y} - {prev_y[POS_W-1], prev_y};
        prev_x = f.x;
        prev_y = f.y;
        return r;
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fails++;
        end
    endtask

    // input accept, prediction and output check
    always @(posedge i_clk) begin
        t_click_report exp_r;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected output word %h", m_data);
                fails++;
            end else begin
                exp_r = expected_reports.pop_front();
                check_field("left_event", exp_r.left, m_data[2:0]);
                check_field("right_event", exp_r.right, m_data[5:3]);
                check_field("middle_event", exp_r.middle, m_data[8:6]);
                check_field("delta_x", exp_r.dx, $signed(m_data[25:9]));
                check_field("delta_y", exp_r.dy, $signed(m_data[42:26]));
            end
        end
        word_taken = i_rst_n && s_valid && s_ready;
        if (word_taken) begin
            expected_reports.push_back(predict_report(t_frame'(s_data[LEVEL_W+TICK_W+2*POS_W-1:0])));
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= IN_W'(pending_frames.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_frame(logic [2:0] lv, logic [31:0] tk, logic [15:0] x, logic [15:0] y);
        t_frame f;
        f.levels = lv;
        f.tick   = tk;
        f.x      = x;
        f.y      = y;
        pending_frames.push_back(f);
    endtask

    task automatic gen_frames(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                add_frame(3'($urandom), $urandom, 16'($urandom), 16'($urandom));
            end else begin
                for (int b = 0; b < EV_FIELDS; b++) begin
                    if ($urandom_range(99) < 35) gen_levels[b] = ~gen_levels[b];
                end
                r = $urandom_range(99);
                if (r < 10) gen_tick = gen_tick + $urandom;
                else if (r < 25) gen_tick = gen_tick + $urandom_range(4 * gen_span + 4);
                else gen_tick = gen_tick + $urandom_range(gen_span);
                r = $urandom_range(99);
                if (r < 60) begin
                    gen_x = gen_x + 16'($urandom_range(128)) - 16'd64;
                    gen_y = gen_y + 16'($urandom_range(128)) - 16'd64;
                end else if (r < 80) begin
                    gen_x = 16'($urandom);
                    gen_y = 16'($urandom);
                end else begin
                    gen_x = $urandom_range(1) ? 16'h7fff : 16'h8000;
                    gen_y = $urandom_range(1) ? 16'hffff : 16'h0000;
                end
                add_frame(gen_levels, gen_tick, gen_x, gen_y);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0 || s_valid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_window(logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        window_cfg = value;
        @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] win;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, window at reset value
        add_frame(3'b000, 32'd0, 16'h7fff, 16'h8000);
        add_frame(3'b111, 32'd10, 16'h8000, 16'h7fff);
        add_frame(3'b111, 32'd20, 16'h0000, 16'hffff);
        add_frame(3'b000, 32'd100, 16'hffff, 16'h0000);
        add_frame(3'b111, 32'd200, 16'h0001, 16'h0001);
        add_frame(3'b000, 32'd510, 16'h0001, 16'h0001);
        // left: late second press restarts the window, late release stays up
        add_frame(3'b001, 32'd1000, 16'd5, 16'd5);
        add_frame(3'b000, 32'd1100, 16'd5, 16'd5);
        add_frame(3'b001, 32'd1600, 16'd5, 16'd5);
        add_frame(3'b000, 32'd1700, 16'd5, 16'd5);
        add_frame(3'b001, 32'd1800, 16'd5, 16'd5);
        add_frame(3'b000, 32'd2200, 16'd5, 16'd5);
        // right: release after the window clears the count
        add_frame(3'b010, 32'd3000, 16'd9, 16'd9);
        add_frame(3'b000, 32'd3600, 16'd9, 16'd9);
        add_frame(3'b010, 32'd3700, 16'd9, 16'd9);
        add_frame(3'b000, 32'd3800, 16'd9, 16'd9);
        // middle: double click across the tick wrap
        add_frame(3'b100, 32'hffffff00, 16'd0, 16'd0);
        add_frame(3'b000, 32'hffffff10, 16'd0, 16'd0);
        add_frame(3'b100, 32'h00000010, 16'd0, 16'd0);
        add_frame(3'b000, 32'h00000050, 16'd0, 16'd0);
        add_frame(3'b110, 32'hffffffff, 16'h7fff, 16'h7fff);
        add_frame(3'b000, 32'hffffffff, 16'h8000, 16'h8000);
        gen_tick = 32'h100;
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin win = 32'd0; gen_span = 16; end
                1: begin win = 32'hffffffff; gen_span = 3000; gen_tick = 32'hfffff000; end
                2: begin win = 32'd37; gen_span = 30; end
                3: begin win = $urandom_range(3000, 100); gen_span = win / 2; end
                default: begin win = 32'd500; gen_span = 300; end
            endcase
            write_window(win);
            @(posedge i_clk);
            send_idle_pct  = (p == 1) ? 50 : (p == 3) ? 26 : 0;
            recv_stall_pct = (p == 2) ? 50 : (p == 3) ? 26 : 0;
            if (p == 4) hold_req = 1'b1;
            gen_frames(346);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bedc_pkg.sv
rtl/core/button_edge_double_click_detector_core.sv
rtl/core/bedc_checker.sv
bench/tb_top.sv
